/* rtl/pls_pkg.sv */
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants for the positional list store
// Sizes of the entry row, operation and status codes, cell control bundle.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int COUNT_W   = $clog2(DEPTH + 1);
    localparam int CAP_W     = 5;
    localparam int POS_W     = 5;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;

    localparam logic [CAP_W-1:0]  CAP_RESET    = CAP_W'(10);
    localparam logic              REG_CAPACITY = 1'b0;
    localparam logic [DATA_W-1:0] READ_ERROR   = '1;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [COUNT_W-1:0]   t_count;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOCATE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_POS  = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    // Per-cell command for the current beat.
    typedef struct packed {
        logic load;
        logic take_left;
        logic take_right;
    } t_cell_ctrl;

endpackage

/* rtl/pls_cell.sv */
// ----------------------------------------------------------------------------
// pls_cell: one slot of the list row
// Holds one entry, loads a new value or takes its left or right neighbor.
// ----------------------------------------------------------------------------
module pls_cell (
    input  logic               i_clk,
    input  pls_pkg::t_cell_ctrl i_ctrl,
    input  pls_pkg::t_word     i_value,
    input  pls_pkg::t_word     i_left,
    input  pls_pkg::t_word     i_right,
    output pls_pkg::t_word     o_entry,
    output logic               o_match
);

    pls_pkg::t_word r_entry;
    pls_pkg::t_word n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.load) begin
            n_entry = i_value;
        end else if (i_ctrl.take_left) begin
            n_entry = i_left;
        end else if (i_ctrl.take_right) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_match = (r_entry == i_value);

endmodule

/* rtl/pls_apb_regs.sv */
// ----------------------------------------------------------------------------
// pls_apb_regs: configuration register file
// Holds the capacity limit, written and read over the APB-style port.
// ----------------------------------------------------------------------------
module pls_apb_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pls_pkg::ADDR_W-1:0]   paddr,
    input  logic [pls_pkg::DATA_W-1:0]   pwdata,
    output logic [pls_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output logic [pls_pkg::CAP_W-1:0]    o_capacity
);

    logic [pls_pkg::CAP_W-1:0] r_capacity;
    logic                      w_sel_cap;
    logic                      w_write;

    assign pready    = 1'b1;
    assign w_sel_cap = (paddr[2] == pls_pkg::REG_CAPACITY);
    assign w_write   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= pls_pkg::CAP_RESET;
        end else if (w_write && w_sel_cap) begin
            r_capacity <= pwdata[pls_pkg::CAP_W-1:0];
        end
    end

    // Byte lanes below the word offset do not select anything.
    always_comb begin
        prdata = '0;
        if (w_sel_cap && (paddr[1:0] == 2'b00 || paddr[1:0] != 2'b00)) begin
            prdata = pls_pkg::DATA_W'(r_capacity);
        end
    end

    assign o_capacity = r_capacity;

endmodule

/* rtl/positional_list_store.sv */
// ----------------------------------------------------------------------------
// positional_list_store: bounded ordered list with positional insert/delete
// Output: a result is presented in the cycle after its request beat is taken.
// Throughput: one request beat per cycle while the result side does not stall;
// the row of cells shifts, loads and compares for a whole request as it is taken.
// Reset: entry count cleared, capacity limit back to 10; entry storage is not
// cleared, since only entries below the count are ever observed.
// ----------------------------------------------------------------------------
module positional_list_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_operation,
    input  logic [pls_pkg::POS_W-1:0]     i_position,
    input  logic signed [31:0]            i_value,
    // Result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic [4:0]                    o_found_position,
    output logic signed [31:0]            o_read_value,
    output logic [4:0]                    o_entry_total,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pls_pkg::ADDR_W-1:0]    paddr,
    input  logic [pls_pkg::DATA_W-1:0]    pwdata,
    output logic [pls_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [pls_pkg::CAP_W-1:0] w_capacity;

    pls_apb_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (w_capacity)
    );

    // ------------------------------------------------------------------
    // Handshake. The result register parts the two channels: a new request
    // beat is taken whenever the result slot is empty or is being drained in
    // the same cycle, so back-to-back requests flow at full rate.
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic w_accept;

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    // ------------------------------------------------------------------
    // Request decode and range checks against the current entry count.
    // ------------------------------------------------------------------
    pls_pkg::t_op   w_op;
    pls_pkg::t_count r_count;
    pls_pkg::t_count n_count;
    pls_pkg::t_word w_key;

    logic [pls_pkg::COUNT_W:0] w_pos_ext;
    logic [pls_pkg::COUNT_W:0] w_cnt_ext;
    logic [pls_pkg::COUNT_W:0] w_cap_eff;
    logic [pls_pkg::POS_W-1:0] w_pos_idx;
    logic                      w_pos_nonzero;
    logic                      w_ins_pos_ok;
    logic                      w_pos_ok;
    logic                      w_full;
    logic                      w_do_ins;
    logic                      w_do_del;

    assign w_op      = pls_pkg::t_op'(i_operation);
    assign w_key     = pls_pkg::WORD_BITS'(i_value);
    assign w_pos_ext = (pls_pkg::COUNT_W + 1)'(i_position);
    assign w_cnt_ext = (pls_pkg::COUNT_W + 1)'(r_count);
    assign w_pos_idx = i_position - pls_pkg::POS_W'(1);

    // The effective capacity never exceeds the number of cells in the row.
    assign w_cap_eff = ((pls_pkg::COUNT_W + 1)'(w_capacity) <
                        (pls_pkg::COUNT_W + 1)'(pls_pkg::DEPTH))
                     ? (pls_pkg::COUNT_W + 1)'(w_capacity)
                     : (pls_pkg::COUNT_W + 1)'(pls_pkg::DEPTH);

    assign w_pos_nonzero = (i_position != '0);
    // Insert may also append right after the last entry.
    assign w_ins_pos_ok  = w_pos_nonzero && (w_pos_ext <= w_cnt_ext + 1'b1);
    assign w_pos_ok      = w_pos_nonzero && (w_pos_ext <= w_cnt_ext);
    assign w_full        = (w_cnt_ext >= w_cap_eff);

    assign w_do_ins = w_accept && (w_op == pls_pkg::OP_INSERT) && w_ins_pos_ok && !w_full;
    assign w_do_del = w_accept && (w_op == pls_pkg::OP_DELETE) && w_pos_ok;

    // ------------------------------------------------------------------
    // Row of cells. On an insert the cell at the target slot loads the new
    // value and every cell above it takes its lower neighbor; on a delete the
    // target cell and every cell above it take their upper neighbor. Cells
    // above the count may pick up stale data, which is never observed.
    // ------------------------------------------------------------------
    pls_pkg::t_word     w_entry [pls_pkg::DEPTH];
    logic               w_match [pls_pkg::DEPTH];
    pls_pkg::t_cell_ctrl w_ctrl [pls_pkg::DEPTH];

    for (genvar g = 0; g < pls_pkg::DEPTH; g++) begin : g_cell
        pls_pkg::t_word w_left;
        pls_pkg::t_word w_right;
        logic           w_at;
        logic           w_above;

        assign w_at    = (w_pos_idx == pls_pkg::POS_W'(g));
        assign w_above = (pls_pkg::POS_W'(g) > w_pos_idx);

        assign w_ctrl[g].load       = w_do_ins && w_at;
        assign w_ctrl[g].take_left  = w_do_ins && w_above;
        assign w_ctrl[g].take_right = w_do_del && (w_at || w_above);

        if (g == 0) begin : g_first
            assign w_left = w_key;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end

        if (g == pls_pkg::DEPTH - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end

        pls_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl[g]),
            .i_value (w_key),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[g]),
            .o_match (w_match[g])
        );
    end

    // ------------------------------------------------------------------
    // Locate: each cell compares against the key in parallel; the lowest
    // matching slot below the count wins. Scanning from the top down leaves
    // the first match in place.
    // ------------------------------------------------------------------
    logic [4:0] w_found;

    always_comb begin
        w_found = '0;
        for (int j = pls_pkg::DEPTH - 1; j >= 0; j--) begin
            if (w_match[j] && (pls_pkg::COUNT_W'(j) < r_count)) begin
                w_found = 5'(j + 1);
            end
        end
    end

    // Read: one slot picked by position.
    pls_pkg::t_word w_read_word;

    assign w_read_word = w_entry[w_pos_idx[pls_pkg::IDX_W-1:0]];

    // ------------------------------------------------------------------
    // Result and count update.
    // ------------------------------------------------------------------
    pls_pkg::t_status   w_status;
    logic [4:0]         w_found_out;
    logic [31:0]        w_read_out;

    always_comb begin
        w_status    = pls_pkg::ST_OK;
        w_found_out = '0;
        w_read_out  = '0;
        n_count     = r_count;
        unique case (w_op)
            pls_pkg::OP_INSERT: begin
                if (!w_ins_pos_ok) begin
                    w_status = pls_pkg::ST_BAD_POS;
                end else if (w_full) begin
                    w_status = pls_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            pls_pkg::OP_DELETE: begin
                if (!w_pos_ok) begin
                    w_status = pls_pkg::ST_BAD_POS;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            pls_pkg::OP_LOCATE: begin
                w_found_out = w_found;
            end
            pls_pkg::OP_READ: begin
                if (!w_pos_ok) begin
                    w_status   = pls_pkg::ST_BAD_POS;
                    w_read_out = pls_pkg::READ_ERROR;
                end else begin
                    w_read_out = 32'(signed'(w_read_word));
                end
            end
            default: begin
                w_status = pls_pkg::ST_OK;
            end
        endcase
    end

    logic [1:0]  r_status;
    logic [4:0]  r_found;
    logic [31:0] r_read;
    logic [4:0]  r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_status;
            r_found  <= w_found_out;
            r_read   <= w_read_out;
            r_total  <= 5'(n_count);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_found_position = r_found;
    assign o_read_value     = signed'(r_read);
    assign o_entry_total    = r_total;

endmodule

/* tb/positional_list_store_test.sv */
// ----------------------------------------------------------------------------
// positional_list_store_test: self-checking bench for the positional list
// Drives insert, delete, locate and read requests with bursty valid and a
// stalling result side, tracks the list in a local copy, and compares every
// result beat field by field against that copy or a typed-in reply.
// ----------------------------------------------------------------------------
module positional_list_store_test;

    import pls_pkg::*;

    // Run shape. Each random phase runs under one capacity setting.
    localparam int PHASE_ITEMS  = 240;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 4;
    localparam int TIMEOUT      = 2000000;

    localparam logic [ADDR_W-1:0] CAP_ADDR = ADDR_W'(4 * int'(REG_CAPACITY));

    // One result beat as the list should report it.
    typedef struct packed {
        t_status     status;
        logic [4:0]  found;
        logic [31:0] rd;
        logic [4:0]  total;
    } t_reply;

    // A row of the directed table is either a request beat or a capacity write.
    typedef enum logic {
        ROW_REQUEST,
        ROW_CAPACITY
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        t_op         op;
        logic [4:0]  pos;
        logic [31:0] val;
        logic        pinned;
        t_reply      reply;
    } t_row;

    // Result-side stall patterns.
    typedef enum logic [2:0] {
        RX_STEADY,
        RX_HALF,
        RX_MOSTLY,
        RX_SPARSE,
        RX_EVERY_THIRD
    } t_rx_mode;

    // ------------------------------------------------------------------------
    // Block ports. Every input is given a known value from time zero.
    // ------------------------------------------------------------------------
    logic                   i_clk            = 1'b0;
    logic                   i_rst_n          = 1'b0;
    logic                   i_valid          = 1'b0;
    logic                   o_ready;
    logic [1:0]             i_operation      = '0;
    logic [POS_W-1:0]       i_position       = '0;
    logic signed [31:0]     i_value          = '0;
    logic                   o_valid;
    logic                   i_ready          = 1'b0;
    logic [1:0]             o_status;
    logic [4:0]             o_found_position;
    logic signed [31:0]     o_read_value;
    logic [4:0]             o_entry_total;
    logic                   psel             = 1'b0;
    logic                   penable          = 1'b0;
    logic                   pwrite           = 1'b0;
    logic [ADDR_W-1:0]      paddr            = '0;
    logic [DATA_W-1:0]      pwdata           = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    // Side-band that travels with each request beat: when pinned is set, the
    // typed-in reply replaces the computed one for that beat.
    logic                   beat_pinned      = 1'b0;
    t_reply                 beat_reply       = '0;

    // Local copy of the list and its capacity register.
    logic [31:0]            list_words [DEPTH];
    int                     list_len         = 0;
    int                     cap_limit        = int'(CAP_RESET);

    // Replies owed by the block, oldest first.
    t_reply                 replies_due [$];

    int                     fails            = 0;
    int                     n_ok             = 0;
    int                     n_bad            = 0;
    int                     n_full           = 0;
    int                     n_settings       = 0;

    // Sender burst state and the long result-side hold-off handshake.
    int                     burst_left       = 0;
    int                     hold_asked       = 0;
    int                     hold_served      = 0;
    int                     hold_left        = 0;
    t_rx_mode               rx_mode          = RX_STEADY;
    int                     rx_span          = 0;
    int                     rx_tick          = 0;

    positional_list_store dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_read_value     (o_read_value),
        .o_entry_total    (o_entry_total),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // List behavior. Applies one request to the local copy and returns the
    // reply the block must give. The position is checked before fullness on
    // an insert, and a capacity below the current length only blocks inserts.
    // ------------------------------------------------------------------------
    function automatic t_reply list_apply(t_op op, logic [4:0] pos, logic [31:0] val);
        t_reply r;
        int     p;
        int     room;
        r    = '{status: ST_OK, found: '0, rd: '0, total: '0};
        p    = int'(pos);
        room = (cap_limit < DEPTH) ? cap_limit : DEPTH;
        case (op)
            OP_INSERT: begin
                if (p < 1 || p > list_len + 1) begin
                    r.status = ST_BAD_POS;
                end else if (list_len >= room) begin
                    r.status = ST_FULL;
                end else begin
                    for (int j = list_len; j >= p; j--)
                        list_words[j] = list_words[j-1];
                    list_words[p-1] = val;
                    list_len++;
                end
            end
            OP_DELETE: begin
                if (p < 1 || p > list_len) begin
                    r.status = ST_BAD_POS;
                end else begin
                    for (int j = p - 1; j < list_len - 1; j++)
                        list_words[j] = list_words[j+1];
                    list_len--;
                end
            end
            OP_LOCATE: begin
                // First match wins, so later duplicates never report.
                for (int j = 0; j < list_len; j++)
                    if (r.found == '0 && list_words[j] == val)
                        r.found = 5'(j + 1);
            end
            default: begin
                if (p < 1 || p > list_len) begin
                    r.status = ST_BAD_POS;
                    r.rd     = READ_ERROR;
                end else begin
                    r.rd = list_words[p-1];
                end
            end
        endcase
        r.total = 5'(list_len);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Beat monitor. Both channels are sampled on the rising edge, so the
    // values seen are the ones that were stable before it. A result beat is
    // matched against the oldest owed reply; an accepted request beat is
    // applied to the local copy and its reply queued.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (replies_due.size() == 0) begin
                    $error("result beat arrived with no reply owed");
                    fails++;
                end else begin
                    want = replies_due.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        fails++;
                    end
                    if (o_found_position !== want.found) begin
                        $error("found_position: expected %0d, got %0d",
                               want.found, o_found_position);
                        fails++;
                    end
                    if (o_read_value !== want.rd) begin
                        $error("read_value: expected %0d, got %0d",
                               $signed(want.rd), o_read_value);
                        fails++;
                    end
                    if (o_entry_total !== want.total) begin
                        $error("entry_total: expected %0d, got %0d",
                               want.total, o_entry_total);
                        fails++;
                    end
                    case (want.status)
                        ST_OK:      n_ok++;
                        ST_BAD_POS: n_bad++;
                        default:    n_full++;
                    endcase
                end
            end
            if (i_valid && o_ready) begin
                want = list_apply(t_op'(i_operation), i_position, i_value);
                // The copy always advances; a typed-in reply only overrides
                // what is queued for this beat.
                if (beat_pinned)
                    want = beat_reply;
                replies_due.push_back(want);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result-side ready. It wanders between stall patterns of random length.
    // When the stimulus asks for a hold-off, ready stays low for a long
    // stretch counted here, so the block fills and pushes back on requests.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_asked != hold_served) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (rx_span == 0) begin
            rx_mode = t_rx_mode'($urandom_range(4));
            rx_span = $urandom_range(150, 40);
        end
        rx_span--;
        rx_tick++;
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_STEADY:  i_ready <= 1'b1;
                RX_HALF:    i_ready <= ($urandom_range(1) == 1);
                RX_MOSTLY:  i_ready <= ($urandom_range(9) < 8);
                RX_SPARSE:  i_ready <= ($urandom_range(9) < 2);
                default:    i_ready <= (rx_tick % 3 == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Request sender. Beats go out in bursts of random length; between bursts
    // valid drops for a random gap, and some bursts follow with no gap at all.
    // Valid is raised with its payload and held until the beat is taken.
    // Called and returns on a rising edge.
    // ------------------------------------------------------------------------
    task automatic offer_request(input t_op op, input logic [4:0] pos,
                                 input logic [31:0] val, input logic pinned,
                                 input t_reply reply);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(8, 1);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_operation <= op;
        i_position  <= pos;
        i_value     <= val;
        beat_pinned <= pinned;
        beat_reply  <= reply;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Stops offering and waits until every owed reply has come back. Since
    // every request yields a result, the block is idle once the queue is empty.
    task automatic drain_replies();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (replies_due.size() != 0);
    endtask

    // Writes the capacity register through the APB port, then reads it back.
    // The local copy takes the new value at the edge that completes the write.
    task automatic write_capacity(input int cap);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= DATA_W'(cap);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cap_limit = cap;
        n_settings++;
        // Straight into the setup cycle of the read-back.
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[CAP_W-1:0] !== CAP_W'(cap)) begin
            $error("capacity_limit: expected %0d, got %0d", cap, prdata[CAP_W-1:0]);
            fails++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random request. Mostly well-formed: positions land inside the range the
    // operation accepts, and locates often look for a value that is stored.
    // The rest use any position from 0 to 17. The list length read here
    // only steers the mix; checking never depends on it.
    task automatic pick_request(output t_op op, output logic [4:0] pos,
                                output logic [31:0] val);
        int sel;
        int len;
        int span;
        sel = $urandom_range(99);
        len = list_len;
        if (sel < 38)
            op = OP_INSERT;
        else if (sel < 62)
            op = OP_DELETE;
        else if (sel < 80)
            op = OP_LOCATE;
        else
            op = OP_READ;
        span = (op == OP_INSERT) ? len + 1 : len;
        if (span > 0 && $urandom_range(99) < 85)
            pos = 5'($urandom_range(span, 1));
        else
            pos = 5'($urandom_range(17));
        case ($urandom_range(9))
            0:       val = 32'h7FFF_FFFF;
            1:       val = 32'h8000_0000;
            2:       val = '1;
            3:       val = '0;
            4, 5:    val = 32'($urandom_range(7));
            6, 7:    val = (len > 0) ? list_words[$urandom_range(len - 1)] : $urandom;
            default: val = $urandom;
        endcase
    endtask

    function automatic t_row req_row(t_op op, int pos, logic [31:0] val);
        return '{kind: ROW_REQUEST, op: op, pos: 5'(pos), val: val,
                 pinned: 1'b0, reply: '0};
    endfunction

    function automatic t_row pinned_row(t_op op, int pos, logic [31:0] val,
                                        t_status st, int found,
                                        logic [31:0] rd, int total);
        return '{kind: ROW_REQUEST, op: op, pos: 5'(pos), val: val, pinned: 1'b1,
                 reply: '{status: st, found: 5'(found), rd: rd, total: 5'(total)}};
    endfunction

    function automatic t_row cap_row(int cap);
        return '{kind: ROW_CAPACITY, op: OP_INSERT, pos: '0, val: 32'(cap),
                 pinned: 1'b0, reply: '0};
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence: reset, the directed table, then random phases that each
    // start from an idle block with a fresh capacity setting.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_row        rows [$];
        int          phase_caps [$];
        t_op         op;
        logic [4:0]  pos;
        logic [31:0] val;

        // Directed table. Replies are typed in where they are obvious; the
        // rest are left to the local copy. The list starts empty with room
        // for ten entries.
        rows.push_back(pinned_row(OP_READ,   1, 32'd0, ST_BAD_POS, 0, READ_ERROR, 0));
        rows.push_back(pinned_row(OP_DELETE, 0, 32'd0, ST_BAD_POS, 0, 32'd0, 0));
        rows.push_back(pinned_row(OP_INSERT, 0, 32'd5, ST_BAD_POS, 0, 32'd0, 0));
        rows.push_back(pinned_row(OP_INSERT, 2, 32'd5, ST_BAD_POS, 0, 32'd0, 0));
        rows.push_back(pinned_row(OP_LOCATE, 0, 32'd0, ST_OK, 0, 32'd0, 0));
        // Build MIN, 0, MAX, -1 by inserting at the front, the back and
        // the middle.
        rows.push_back(pinned_row(OP_INSERT, 1, 32'h7FFF_FFFF, ST_OK, 0, 32'd0, 1));
        rows.push_back(pinned_row(OP_INSERT, 1, 32'h8000_0000, ST_OK, 0, 32'd0, 2));
        rows.push_back(pinned_row(OP_INSERT, 3, 32'hFFFF_FFFF, ST_OK, 0, 32'd0, 3));
        rows.push_back(pinned_row(OP_INSERT, 2, 32'd0, ST_OK, 0, 32'd0, 4));
        rows.push_back(pinned_row(OP_READ,   1, 32'd0, ST_OK, 0, 32'h8000_0000, 4));
        // A stored -1 reads back with a good status.
        rows.push_back(pinned_row(OP_READ,   4, 32'd0, ST_OK, 0, 32'hFFFF_FFFF, 4));
        rows.push_back(pinned_row(OP_READ,   5, 32'd0, ST_BAD_POS, 0, READ_ERROR, 4));
        rows.push_back(pinned_row(OP_READ,  17, 32'd0, ST_BAD_POS, 0, READ_ERROR, 4));
        rows.push_back(req_row(OP_LOCATE,  0, 32'h7FFF_FFFF));
        rows.push_back(req_row(OP_INSERT,  5, 32'h5A5A_A5A5));
        rows.push_back(req_row(OP_LOCATE,  9, 32'h0000_1234));
        rows.push_back(req_row(OP_DELETE,  1, 32'd0));
        rows.push_back(pinned_row(OP_DELETE, 5, 32'd0, ST_BAD_POS, 0, 32'd0, 4));
        rows.push_back(pinned_row(OP_INSERT, 6, 32'd1, ST_BAD_POS, 0, 32'd0, 4));
        // Capacity dropped below the length: inserts are refused as full,
        // but a bad position still wins over fullness.
        rows.push_back(cap_row(1));
        rows.push_back(pinned_row(OP_INSERT, 2, 32'd7, ST_FULL, 0, 32'd0, 4));
        rows.push_back(pinned_row(OP_INSERT, 9, 32'd7, ST_BAD_POS, 0, 32'd0, 4));
        rows.push_back(req_row(OP_DELETE,  4, 32'd0));
        rows.push_back(req_row(OP_READ,    2, 32'd0));
        rows.push_back(cap_row(DEPTH));
        rows.push_back(req_row(OP_INSERT,  4, 32'h0F0F_0F0F));

        // Capacity per random phase. The first full-size phase is followed by the
        // smallest setting, so the list is likely to sit above its limit.
        phase_caps = '{DEPTH, 1, 7, DEPTH, 3, $urandom_range(DEPTH, 1), 12, 1};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            if (rows[k].kind == ROW_CAPACITY) begin
                drain_replies();
                write_capacity(int'(rows[k].val));
            end else begin
                offer_request(rows[k].op, rows[k].pos, rows[k].val,
                              rows[k].pinned, rows[k].reply);
            end
        end

        foreach (phase_caps[ph]) begin
            drain_replies();
            write_capacity(phase_caps[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // A long result-side hold-off while requests keep coming.
                if (n == 100 && (ph == 0 || ph == 4))
                    hold_asked++;
                // Mid-phase the sender waits for the block to empty out.
                if (n == PHASE_ITEMS / 2)
                    drain_replies();
                pick_request(op, pos, val);
                offer_request(op, pos, val, 1'b0, '0);
            end
        end

        drain_replies();
        repeat (SETTLE) @(posedge i_clk);
        if (replies_due.size() != 0) begin
            $error("%0d replies never arrived", replies_due.size());
            fails++;
        end

        $display("Covered %0d result beats under %0d capacity settings:",
                 n_ok + n_bad + n_full, n_settings);
        $display("  %0d good, %0d bad position, %0d refused for a full list.",
                 n_ok, n_bad, n_full);
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #(TIMEOUT);
        $display("FAIL");
        $finish;
    end

endmodule

/* positional_list_store.f */
rtl/pls_pkg.sv
rtl/pls_cell.sv
rtl/pls_apb_regs.sv
rtl/positional_list_store.sv
tb/positional_list_store_test.sv
